@@ design/fdcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcs_pkg
// Shared types, codes and constants of the distinct-count sketch unit.
// ----------------------------------------------------------------------------
package fdcs_pkg;

  localparam int MAX_ROWS_DEF     = 64;
  localparam int BITMAP_WIDTH_DEF = 32;

  localparam logic [16:0] SCALE_Q16 = 17'd84726;
  localparam logic [32:0] EST_MAX   = 33'h1_FFFF_FFFF;
  localparam logic [11:0] SUM_MAX   = 12'hFFF;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_LOAD   = 2'd2,
    OP_MERGE  = 2'd3
  } op_t;

  localparam logic REG_ACTIVE_ROWS  = 1'b0;
  localparam logic REG_HASH_MODULUS = 1'b1;

  typedef enum logic [1:0] {
    DIV_PRIME   = 2'd0,
    DIV_MODULUS = 2'd1,
    DIV_AVERAGE = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     clr_work;
    logic     rd_bm;
    logic     rd_coef;
    logic     sel_row;
    logic     hash;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_rem;
    logic     set_bit;
    logic     idx_inc;
    logic     acc_add;
    logic     take_quot;
    logic     pow_step;
    logic     shift;
    logic     scale;
    logic     wr_coef;
    logic     merge_wr;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic p_zero;
    logic m_zero;
    logic div_done;
    logic last_row;
    logic row_ok;
    logic pow_last;
    logic out_busy;
  } stat_t;

  typedef logic [23:0][31:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      b = 64'h1 << (2 * i);
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic root_tab_t build_roots();
    root_tab_t   t;
    logic [63:0] s;
    s = isqrt64(64'h1 << 61);
    for (int j = 23; j >= 0; j--) begin
      t[j] = s[31:0];
      s = isqrt64(s << 30);
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

endpackage

@@ design/fm_distinct_count_sketch_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_distinct_count_sketch_unit
// Flajolet-Martin distinct-count sketch: insert, query, load and merge items.
//
// Channel   Handshake                 Payload
// in        in_valid / in_ready       op, item_id, row_select, coef_mult,
//                                     coef_add, prime_mod, merge_bits
// out       out_valid / out_ready     new_bit_set, zero_sum, estimate
// cfg       cfg_write                 cfg_index, cfg_data
//
// Insert makes up to two passes of the shared restoring divider per row (one
// for the row prime, one for the hash modulus). Query makes one divider pass
// and 24 power steps. Load and merge make no divider pass.
// One item is in work at a time; the output register lets the next item
// start while a result waits. Reset is synchronous and clears all bitmaps
// at once through per-row valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fm_distinct_count_sketch_unit #(
  parameter int MAX_ROWS     = fdcs_pkg::MAX_ROWS_DEF,
  parameter int BITMAP_WIDTH = fdcs_pkg::BITMAP_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [32:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] item_id,
  input  logic [5:0]  row_select,
  input  logic [30:0] coef_mult,
  input  logic [30:0] coef_add,
  input  logic [30:0] prime_mod,
  input  logic [31:0] merge_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        new_bit_set,
  output logic [11:0] zero_sum,
  output logic [32:0] estimate
);
  import fdcs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fdcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fdcs_datapath #(
    .MAX_ROWS     (MAX_ROWS),
    .BITMAP_WIDTH (BITMAP_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .op          (op),
    .item_id     (item_id),
    .row_select  (row_select),
    .coef_mult   (coef_mult),
    .coef_add    (coef_add),
    .prime_mod   (prime_mod),
    .merge_bits  (merge_bits),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .new_bit_set (new_bit_set),
    .zero_sum    (zero_sum),
    .estimate    (estimate)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while sequencer busy");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without an item in work");

  a_insert_result_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_bit_set |-> zero_sum == 12'd0 && estimate == 33'd0)
    else $error("insert result carries query fields");

endmodule

@@ design/fdcs_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcs_divider
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module fdcs_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [32:0] rem
);

  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] dsr;
  logic [33:0] trial;

  assign trial = {rem, quot[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      rem  <= '0;
      quot <= dividend;
      dsr  <= divisor;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (trial >= {1'b0, dsr}) begin
        rem  <= 33'(trial - {1'b0, dsr});
        quot <= {quot[62:0], 1'b1};
      end else begin
        rem  <= trial[32:0];
        quot <= {quot[62:0], 1'b0};
      end
    end
  end

endmodule

@@ design/fdcs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcs_datapath
// Row memories, configuration registers, hash, divider and estimate path.
// ----------------------------------------------------------------------------
module fdcs_datapath #(
  parameter int MAX_ROWS     = 64,
  parameter int BITMAP_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [32:0]         cfg_data,
  input  logic [1:0]          op,
  input  logic [31:0]         item_id,
  input  logic [5:0]          row_select,
  input  logic [30:0]         coef_mult,
  input  logic [30:0]         coef_add,
  input  logic [30:0]         prime_mod,
  input  logic [31:0]         merge_bits,
  input  fdcs_pkg::cmd_t      cmd,
  output fdcs_pkg::stat_t     stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                new_bit_set,
  output logic [11:0]         zero_sum,
  output logic [32:0]         estimate
);
  import fdcs_pkg::*;

  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCW  = $clog2(MAX_ROWS + 1);
  localparam int BPW  = $clog2(BITMAP_WIDTH + 1);
  localparam int SUMW = $clog2(MAX_ROWS * BITMAP_WIDTH + 1);
  localparam int SUMX = (SUMW > 12) ? SUMW : 12;

  function automatic logic [6:0] trail_zeros(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd1;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) n = 7'(i);
    end
    return n;
  endfunction

  function automatic logic [BPW-1:0] low_clear(input logic [BITMAP_WIDTH-1:0] v);
    logic [BPW-1:0] n;
    n = BPW'(BITMAP_WIDTH);
    for (int i = BITMAP_WIDTH - 1; i >= 0; i--) begin
      if (!v[i]) n = BPW'(i);
    end
    return n;
  endfunction

  logic [6:0]  active_rows;
  logic [32:0] hash_modulus;
  logic [RCW-1:0] rows;

  op_t         op_r;
  logic [31:0] id_r;
  logic [8:0]  row_r;
  logic [30:0] a_r, b_r, p_r;
  logic [31:0] merge_r;

  logic [BITMAP_WIDTH-1:0] bm_mem [MAX_ROWS];
  logic [30:0]             mult_mem [MAX_ROWS];
  logic [30:0]             add_mem [MAX_ROWS];
  logic [30:0]             prime_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]     bm_valid;

  logic [BITMAP_WIDTH-1:0] bm_q, bm_cur, set_mask, bm_wdata;
  logic                    bmv_q, bm_we, new_bit;
  logic [30:0]             mult_q, add_q, prime_q;
  logic [RW-1:0]           idx, bm_addr;

  logic [63:0] h;
  logic [62:0] prod;
  logic [6:0]  pos;
  logic        in_range, fresh;
  logic [SUMW-1:0] sum;
  logic [SUMX-1:0] sum_x;

  logic        div_start_q;
  logic [63:0] div_dividend, div_quot;
  logic [32:0] div_divisor, div_rem;
  logic        div_done;

  logic        k_sat;
  logic [5:0]  k_sh;
  logic [23:0] frac;
  logic [31:0] acc;
  logic [4:0]  j;
  logic [63:0] pow_prod;
  logic [33:0] pwr;
  logic [50:0] scaled;
  logic [32:0] est;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_rows  <= 7'd1;
      hash_modulus <= 33'h1_0000_0000;
    end else if (cfg_write) begin
      if (cfg_index == REG_ACTIVE_ROWS) active_rows <= cfg_data[6:0];
      else hash_modulus <= cfg_data;
    end
  end

  always_comb begin
    if (active_rows == 7'd0) rows = RCW'(1);
    else if (9'(active_rows) > 9'(MAX_ROWS)) rows = RCW'(MAX_ROWS);
    else rows = RCW'(active_rows);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= op_t'(op);
      id_r    <= item_id;
      row_r   <= 9'(row_select);
      a_r     <= coef_mult;
      b_r     <= coef_add;
      p_r     <= prime_mod;
      merge_r <= merge_bits;
    end
  end

  assign bm_addr = cmd.sel_row ? row_r[RW-1:0] : idx;
  assign bm_cur  = bmv_q ? bm_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.rd_bm) begin
      bm_q  <= bm_mem[bm_addr];
      bmv_q <= bm_valid[bm_addr];
    end
    if (cmd.rd_coef) begin
      mult_q  <= mult_mem[idx];
      add_q   <= add_mem[idx];
      prime_q <= prime_mem[idx];
    end
    if (bm_we) bm_mem[bm_addr] <= bm_wdata;
    if (cmd.wr_coef) begin
      mult_mem[row_r[RW-1:0]]  <= a_r;
      add_mem[row_r[RW-1:0]]   <= b_r;
      prime_mem[row_r[RW-1:0]] <= p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) bm_valid <= '0;
    else if (bm_we) bm_valid[bm_addr] <= 1'b1;
  end

  assign pos      = trail_zeros(h);
  assign in_range = pos < 7'(BITMAP_WIDTH);
  assign set_mask = in_range ? (BITMAP_WIDTH'(1) << pos) : '0;
  assign new_bit  = in_range && ((bm_cur & set_mask) == '0);
  assign bm_we    = (cmd.set_bit && new_bit) || cmd.merge_wr;
  assign bm_wdata = cmd.merge_wr ? (bm_cur | BITMAP_WIDTH'(merge_r)) : (bm_cur | set_mask);

  assign prod = 63'(mult_q) * 63'(id_r);

  always_comb begin
    case (cmd.div_sel)
      DIV_PRIME: begin
        div_dividend = h;
        div_divisor  = 33'(prime_q);
      end
      DIV_MODULUS: begin
        div_dividend = h;
        div_divisor  = hash_modulus;
      end
      DIV_AVERAGE: begin
        div_dividend = 64'(sum) << 24;
        div_divisor  = 33'(rows);
      end
      default: begin
        div_dividend = h;
        div_divisor  = hash_modulus;
      end
    endcase
  end

  assign div_start_q = cmd.div_start;

  fdcs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start_q),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.clr_work) begin
      idx   <= '0;
      fresh <= 1'b0;
      sum   <= '0;
    end else begin
      if (cmd.idx_inc) idx <= RW'(idx + RW'(1));
      if (cmd.set_bit && new_bit) fresh <= 1'b1;
      if (cmd.acc_add) sum <= sum + SUMW'(low_clear(bm_cur));
    end
    if (cmd.hash) h <= 64'(prod) + 64'(add_q);
    else if (cmd.take_rem) h <= 64'(div_rem);
  end

  assign pow_prod = 64'(acc) * 64'(ROOT_TAB[j]);
  assign scaled   = 51'(pwr) * 51'(SCALE_Q16);

  always_ff @(posedge clk) begin
    if (cmd.take_quot) begin
      k_sat <= (|div_quot[63:30]) || (div_quot[29:24] > 6'd32);
      k_sh  <= div_quot[29:24];
      frac  <= div_quot[23:0];
      acc   <= 32'h4000_0000;
      j     <= 5'd23;
    end else if (cmd.pow_step) begin
      if (frac[j]) acc <= pow_prod[61:30];
      j <= j - 5'd1;
    end
    if (cmd.shift) pwr <= 34'(({32'b0, acc} << k_sh) >> 30);
    if (cmd.scale) begin
      if (k_sat || scaled[50:16] > 35'(EST_MAX)) est <= EST_MAX;
      else est <= scaled[48:16];
    end
  end

  assign sum_x = SUMX'(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      new_bit_set <= (op_r == OP_INSERT) && fresh;
      zero_sum    <= '0;
      estimate    <= '0;
      if (op_r == OP_QUERY) begin
        zero_sum <= (sum_x > SUMX'(SUM_MAX)) ? SUM_MAX : sum_x[11:0];
        estimate <= est;
      end
    end
  end

  always_comb begin
    stat.op       = op_r;
    stat.p_zero   = prime_q == '0;
    stat.m_zero   = hash_modulus == '0;
    stat.div_done = div_done;
    stat.last_row = RCW'(RCW'(idx) + RCW'(1)) == rows;
    stat.row_ok   = row_r < 9'(MAX_ROWS);
    stat.pow_last = j == 5'd0;
    stat.out_busy = out_valid && !out_ready;
  end

endmodule

@@ design/fdcs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcs_ctrl
// Sequencer: steps the datapath through insert, query, load and merge.
// ----------------------------------------------------------------------------
module fdcs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fdcs_pkg::stat_t stat,
  output fdcs_pkg::cmd_t  cmd
);
  import fdcs_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_DISP  = 20'h00002,
    S_IRD   = 20'h00004,
    S_IMUL  = 20'h00008,
    S_IMODP = 20'h00010,
    S_IWP   = 20'h00020,
    S_IMODM = 20'h00040,
    S_IWM   = 20'h00080,
    S_ISET  = 20'h00100,
    S_QRD   = 20'h00200,
    S_QACC  = 20'h00400,
    S_QDIV  = 20'h00800,
    S_QWD   = 20'h01000,
    S_QPOW  = 20'h02000,
    S_QSHF  = 20'h04000,
    S_QSCL  = 20'h08000,
    S_LOAD  = 20'h10000,
    S_MRD   = 20'h20000,
    S_MWR   = 20'h40000,
    S_DONE  = 20'h80000
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = DIV_PRIME;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture  = 1'b1;
          cmd.clr_work = 1'b1;
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.op)
          OP_INSERT: state_next = S_IRD;
          OP_QUERY:  state_next = S_QRD;
          OP_LOAD:   state_next = S_LOAD;
          OP_MERGE:  state_next = S_MRD;
          default:   state_next = S_DONE;
        endcase
      end
      S_IRD: begin
        cmd.rd_bm   = 1'b1;
        cmd.rd_coef = 1'b1;
        state_next  = S_IMUL;
      end
      S_IMUL: begin
        cmd.hash   = 1'b1;
        state_next = S_IMODP;
      end
      S_IMODP: begin
        if (stat.p_zero) begin
          state_next = S_IMODM;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_IWP;
        end
      end
      S_IWP: begin
        if (stat.div_done) begin
          cmd.take_rem = 1'b1;
          state_next   = S_IMODM;
        end
      end
      S_IMODM: begin
        cmd.div_sel = DIV_MODULUS;
        if (stat.m_zero) begin
          state_next = S_ISET;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_IWM;
        end
      end
      S_IWM: begin
        if (stat.div_done) begin
          cmd.take_rem = 1'b1;
          state_next   = S_ISET;
        end
      end
      S_ISET: begin
        cmd.set_bit = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = stat.last_row ? S_DONE : S_IRD;
      end
      S_QRD: begin
        cmd.rd_bm  = 1'b1;
        state_next = S_QACC;
      end
      S_QACC: begin
        cmd.acc_add = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = stat.last_row ? S_QDIV : S_QRD;
      end
      S_QDIV: begin
        cmd.div_sel   = DIV_AVERAGE;
        cmd.div_start = 1'b1;
        state_next    = S_QWD;
      end
      S_QWD: begin
        if (stat.div_done) begin
          cmd.take_quot = 1'b1;
          state_next    = S_QPOW;
        end
      end
      S_QPOW: begin
        cmd.pow_step = 1'b1;
        if (stat.pow_last) state_next = S_QSHF;
      end
      S_QSHF: begin
        cmd.shift  = 1'b1;
        state_next = S_QSCL;
      end
      S_QSCL: begin
        cmd.scale  = 1'b1;
        state_next = S_DONE;
      end
      S_LOAD: begin
        cmd.wr_coef = stat.row_ok;
        state_next  = S_DONE;
      end
      S_MRD: begin
        cmd.sel_row = 1'b1;
        cmd.rd_bm   = 1'b1;
        state_next  = S_MWR;
      end
      S_MWR: begin
        cmd.sel_row  = 1'b1;
        cmd.merge_wr = stat.row_ok;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
